[design/qpe_pkg.sv]
// shared types, character codes and planning functions for the quoted-printable encoder
package qpe_pkg;

    localparam int COL_W = 7;
    localparam int OPT_W = 4;

    localparam int OPT_LF_ONLY = 0;
    localparam int OPT_BINARY  = 1;
    localparam int OPT_EBCDIC  = 2;
    localparam int OPT_PERIOD  = 3;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_EQ  = 8'h3D;

    typedef enum logic [2:0] {
        CL_PLAIN,
        CL_ESCAPE,
        CL_BLANK,
        CL_CR,
        CL_LF,
        CL_PERIOD
    } class_t;

    typedef enum logic [1:0] {
        U_PLAIN,
        U_HEX,
        U_HARD
    } unit_kind_t;

    // P: resolve held period, M: main byte, D: escape pending period, E: end flush
    typedef enum logic [3:0] {
        PH_P = 4'b0001,
        PH_M = 4'b0010,
        PH_D = 4'b0100,
        PH_E = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       msg_end;
        class_t     cls;
        logic       brk;
    } item_t;

    typedef struct packed {
        phase_t           phase;
        logic [COL_W-1:0] col;
        logic [7:0]       blank;
        logic             period;
        logic             after_cr;
    } enc_state_t;

    localparam enc_state_t ST_RESET = '{phase: PH_P, col: '0, blank: '0,
                                        period: 1'b0, after_cr: 1'b0};

    typedef struct packed {
        unit_kind_t kind;
        logic [7:0] value;
        logic       wrap;
        logic       last;
    } unit_t;

    typedef struct packed {
        logic       has_unit;
        logic       done;
        unit_t      unit;
        enc_state_t nxt;
    } plan_t;

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = 8'h30 + {4'h0, n};
        else
            r = 8'h37 + {4'h0, n};
        return r;
    endfunction

    function automatic class_t classify(logic [7:0] b, logic [OPT_W-1:0] opts);
        class_t c;
        unique case (b) inside
            CH_LF, CH_CR, CH_TAB, CH_SP:
            begin
                if (opts[OPT_BINARY])
                    c = CL_ESCAPE;
                else if (b == CH_CR)
                    c = CL_CR;
                else if (b == CH_LF)
                    c = CL_LF;
                else
                    c = CL_BLANK;
            end
            CH_EQ:
            begin
                c = CL_ESCAPE;
            end
            8'h21, 8'h22, 8'h23, 8'h24, 8'h40, 8'h5B, 8'h5C, 8'h5D,
            8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E:
            begin
                c = opts[OPT_EBCDIC] ? CL_ESCAPE : CL_PLAIN;
            end
            CH_DOT:
            begin
                c = CL_PERIOD;
            end
            default:
            begin
                c = (b < 8'h20 || b > 8'h7E) ? CL_ESCAPE : CL_PLAIN;
            end
        endcase
        return c;
    endfunction

    // picks the next output unit of the current item and the state after it
    function automatic plan_t plan_step(enc_state_t s, item_t it, logic [OPT_W-1:0] opts,
                                        logic [COL_W-1:0] limit);
        plan_t      p;
        logic       issue;
        logic       pc;
        unit_kind_t k;
        logic [7:0] v;
        p     = '0;
        p.nxt = s;
        issue = 1'b0;
        k     = U_PLAIN;
        v     = 8'h00;
        pc    = opts[OPT_PERIOD] && it.cls == CL_PERIOD &&
                (s.col == '0 || s.col >= limit);

        if (s.phase == PH_D)
        begin
            issue       = 1'b1;
            k           = U_HEX;
            v           = CH_DOT;
            p.nxt.phase = PH_E;
        end
        else if (s.phase == PH_P && s.period)
        begin
            issue = 1'b1;
            if (s.blank != 8'h00)
            begin
                k           = U_PLAIN;
                v           = s.blank;
                p.nxt.blank = 8'h00;
            end
            else
            begin
                p.nxt.period = 1'b0;
                p.nxt.phase  = PH_M;
                k            = it.brk ? U_HEX : U_PLAIN;
                v            = CH_DOT;
            end
        end
        else if (s.phase != PH_E)
        begin
            issue       = 1'b1;
            p.nxt.phase = PH_E;
            if (pc)
            begin
                if (!it.msg_end)
                begin
                    issue        = 1'b0;
                    p.nxt.period = 1'b1;
                end
                else if (s.blank != 8'h00)
                begin
                    k           = U_PLAIN;
                    v           = s.blank;
                    p.nxt.blank = 8'h00;
                    p.nxt.phase = PH_D;
                end
                else
                begin
                    k = U_HEX;
                    v = CH_DOT;
                end
            end
            else
            begin
                case (it.cls)
                    CL_BLANK:
                    begin
                        if (s.blank != 8'h00)
                        begin
                            k           = U_PLAIN;
                            v           = s.blank;
                            p.nxt.blank = 8'h00;
                            p.nxt.phase = PH_M;
                        end
                        else
                        begin
                            issue       = 1'b0;
                            p.nxt.blank = it.data;
                        end
                    end
                    CL_CR, CL_LF:
                    begin
                        if (it.cls == CL_LF && s.after_cr)
                            issue = 1'b0;
                        else if (s.blank != 8'h00)
                        begin
                            k           = U_HEX;
                            v           = s.blank;
                            p.nxt.blank = 8'h00;
                            p.nxt.phase = PH_M;
                        end
                        else
                            k = U_HARD;
                    end
                    CL_ESCAPE:
                    begin
                        if (s.blank != 8'h00)
                        begin
                            k           = U_PLAIN;
                            v           = s.blank;
                            p.nxt.blank = 8'h00;
                            p.nxt.phase = PH_M;
                        end
                        else
                        begin
                            k = U_HEX;
                            v = it.data;
                        end
                    end
                    default:
                    begin
                        if (s.blank != 8'h00)
                        begin
                            k           = U_PLAIN;
                            v           = s.blank;
                            p.nxt.blank = 8'h00;
                            p.nxt.phase = PH_M;
                        end
                        else
                        begin
                            k = U_PLAIN;
                            v = it.data;
                        end
                    end
                endcase
            end
        end

        // end of item: flush a held blank at message end
        if (!issue)
        begin
            p.done      = 1'b1;
            p.nxt.phase = PH_P;
            if (it.msg_end && p.nxt.blank != 8'h00)
            begin
                issue       = 1'b1;
                k           = U_HEX;
                v           = p.nxt.blank;
                p.nxt.blank = 8'h00;
            end
        end

        if (issue)
        begin
            p.unit.kind  = k;
            p.unit.value = v;
            if (k == U_PLAIN)
            begin
                p.unit.wrap = (s.col >= limit);
                p.nxt.col   = p.unit.wrap ? COL_W'(1) : s.col + COL_W'(1);
            end
            else if (k == U_HEX)
            begin
                p.unit.wrap = (s.col >= limit - COL_W'(2));
                p.nxt.col   = p.unit.wrap ? COL_W'(3) : s.col + COL_W'(3);
            end
            else
            begin
                p.unit.wrap = 1'b0;
                p.nxt.col   = '0;
            end
        end

        if (p.done)
        begin
            p.nxt.after_cr = (it.cls == CL_CR);
            if (it.msg_end)
            begin
                p.nxt.period   = 1'b0;
                p.nxt.col      = '0;
                p.nxt.after_cr = 1'b0;
                p.nxt.blank    = 8'h00;
            end
        end

        p.has_unit = issue;
        return p;
    endfunction

endpackage

[design/qpe_if.sv]
// channel interfaces for message bytes in and encoded bytes out
interface qpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       message_end;

    modport source (output valid, output in_byte, output message_end, input ready);
    modport sink (input valid, input in_byte, input message_end, output ready);
endinterface

interface qpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

[design/quoted_printable_encoder.sv]
// quoted-printable encoder top level: options register, front, queue, back and output stage
// path: an accepted message beat is registered in the queue, then in the output stage buffer
// throughput: one output beat per cycle while enc.ready is high; an item is issued as output units
//   (plain byte, =XX escape or line break, soft break folded in)
// a plain text byte sustains one item per cycle while the output stage has room; the output stage sets the byte rate
// reset: rst_n clears options, line state, queue and output stage at once
module quoted_printable_encoder #(
    parameter int LINE_LIMIT  = 75,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [qpe_pkg::OPT_W-1:0]   cfg_wdata,
    qpe_in_if.sink                      msg,
    qpe_out_if.source                   enc
);

    localparam logic [qpe_pkg::COL_W-1:0] LIMIT = qpe_pkg::COL_W'(LINE_LIMIT);

    logic [qpe_pkg::OPT_W-1:0] opts_reg, opts_next;
    logic                      push_valid;
    logic                      push_ready;
    qpe_pkg::item_t            push_item;
    logic                      item_valid;
    logic                      item_pop;
    qpe_pkg::item_t            item;
    logic                      emit_free;
    logic                      unit_load;
    qpe_pkg::unit_t            unit;

    assign opts_next = cfg_we ? cfg_wdata : opts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            opts_reg <= '0;
        else
            opts_reg <= opts_next;
    end

    qpe_front u_front (
        .msg        (msg),
        .opts       (opts_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (item_valid),
        .pop_item   (item),
        .pop        (item_pop)
    );

    qpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .opts       (opts_reg),
        .limit      (LIMIT),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .emit_free  (emit_free),
        .unit_load  (unit_load),
        .unit       (unit)
    );

    qpe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .lf_only   (opts_reg[qpe_pkg::OPT_LF_ONLY]),
        .unit_load (unit_load),
        .unit      (unit),
        .emit_free (emit_free),
        .enc       (enc)
    );

endmodule

[design/qpe_front.sv]
// front end: accepts message beats and classifies each byte
module qpe_front (
    qpe_in_if.sink                      msg,
    input  logic [qpe_pkg::OPT_W-1:0]   opts,
    input  logic                        push_ready,
    output logic                        push_valid,
    output qpe_pkg::item_t              push_item
);

    assign msg.ready  = push_ready;
    assign push_valid = msg.valid;

    always_comb
    begin
        push_item.data    = msg.in_byte;
        push_item.msg_end = msg.message_end;
        push_item.cls     = qpe_pkg::classify(msg.in_byte, opts);
        push_item.brk     = (msg.in_byte == qpe_pkg::CH_CR) || (msg.in_byte == qpe_pkg::CH_LF);
    end

endmodule

[design/qpe_queue.sv]
// short queue of classified items between front and back
module qpe_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  qpe_pkg::item_t push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output qpe_pkg::item_t pop_item,
    input  logic           pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qpe_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[design/qpe_back.sv]
// back end: steps through each item, keeps line state and issues output units
module qpe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [qpe_pkg::OPT_W-1:0]   opts,
    input  logic [qpe_pkg::COL_W-1:0]   limit,
    input  logic                        item_valid,
    input  qpe_pkg::item_t              item,
    output logic                        item_pop,
    input  logic                        emit_free,
    output logic                        unit_load,
    output qpe_pkg::unit_t              unit
);

    qpe_pkg::enc_state_t st_reg, st_next;
    qpe_pkg::plan_t      plan_now;
    qpe_pkg::plan_t      plan_ahead;
    logic                fire;
    logic                tail_empty;

    always_comb
    begin
        plan_now   = qpe_pkg::plan_step(st_reg, item, opts, limit);
        plan_ahead = qpe_pkg::plan_step(plan_now.nxt, item, opts, limit);
    end

    // the item ends with no further output after this unit
    assign tail_empty = plan_ahead.done && !plan_ahead.has_unit;
    assign fire       = item_valid && (!plan_now.has_unit || emit_free);
    assign unit_load  = fire && plan_now.has_unit;
    assign item_pop   = fire && (plan_now.done || (plan_now.has_unit && tail_empty));

    always_comb
    begin
        unit      = plan_now.unit;
        unit.last = plan_now.done || tail_empty;
    end

    always_comb
    begin
        st_next = st_reg;
        if (fire)
        begin
            if (!plan_now.done && tail_empty)
                st_next = plan_ahead.nxt;
            else
                st_next = plan_now.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= qpe_pkg::ST_RESET;
        else
            st_reg <= st_next;
    end

endmodule

[design/qpe_emit.sv]
// output stage: expands a unit into bytes and sends one beat per cycle while enc.ready is high
module qpe_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           lf_only,
    input  logic           unit_load,
    input  qpe_pkg::unit_t unit,
    output logic           emit_free,
    qpe_out_if.source      enc
);

    logic [5:0][7:0] buf_reg, buf_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            last_reg, last_next;
    logic [2:0][7:0] pre;
    logic [2:0][7:0] body;
    logic [1:0]      pre_len;
    logic [1:0]      body_len;
    logic [5:0][7:0] bytes;

    assign enc.valid    = (cnt_reg != 3'd0);
    assign enc.out_byte = buf_reg[0];
    assign enc.run_last = last_reg && (cnt_reg == 3'd1);
    assign emit_free    = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && enc.ready);

    always_comb
    begin
        if (!unit.wrap)
        begin
            pre     = '0;
            pre_len = 2'd0;
        end
        else if (lf_only)
        begin
            pre     = {8'h00, qpe_pkg::CH_LF, qpe_pkg::CH_EQ};
            pre_len = 2'd2;
        end
        else
        begin
            pre     = {qpe_pkg::CH_LF, qpe_pkg::CH_CR, qpe_pkg::CH_EQ};
            pre_len = 2'd3;
        end

        unique case (unit.kind)
            qpe_pkg::U_HEX:
            begin
                body     = {qpe_pkg::hex_char(unit.value[3:0]),
                            qpe_pkg::hex_char(unit.value[7:4]), qpe_pkg::CH_EQ};
                body_len = 2'd3;
            end
            qpe_pkg::U_HARD:
            begin
                if (lf_only)
                begin
                    body     = {16'h0000, qpe_pkg::CH_LF};
                    body_len = 2'd1;
                end
                else
                begin
                    body     = {8'h00, qpe_pkg::CH_LF, qpe_pkg::CH_CR};
                    body_len = 2'd2;
                end
            end
            default:
            begin
                body     = {16'h0000, unit.value};
                body_len = 2'd1;
            end
        endcase

        bytes = ({24'h000000, body} << {pre_len, 3'b000}) | {24'h000000, pre};
    end

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (unit_load)
        begin
            buf_next  = bytes;
            cnt_next  = {1'b0, pre_len} + {1'b0, body_len};
            last_next = unit.last;
        end
        else if (enc.valid && enc.ready)
        begin
            buf_next = {8'h00, buf_reg[5:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
    end

endmodule
